>>> design/brf_pkg.sv
// Package for the chunked circular byte FIFO.
// Holds the sizing constants, command codes and the item and result beat types.
// No dependencies.
`default_nettype none

package brf_pkg;

    localparam int DEPTH     = 1024;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int MAX_BURST = 64;
    localparam int CNT_W     = 7;
    localparam int BYTE_W    = 8;
    localparam int CMD_W     = 3;

    localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SKIP  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] data_in;
        logic [CNT_W-1:0]  count;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_out;
        logic              data_valid;
        logic              last;
        logic [CNT_W-1:0]  moved;
        logic [PTR_W-1:0]  used_level;
        logic [PTR_W-1:0]  free_level;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_STREAM = 2'b10
    } state_t;

endpackage

`default_nettype wire

>>> design/brf_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Used for the byte store of the FIFO. No dependencies.
`default_nettype none

module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> design/byte_ring_fifo_chunked.sv
// Top level of the chunked circular byte FIFO.
// Depends on brf_pkg and on brf_ram for the byte store.
//
// Push, skip, clear and unused commands keep busy low, so a new beat may be
// started every cycle, with the result strobed on done in the cycle after the
// command is taken. A pop or peek of n bytes (count saturated to 64 and clamped
// to the fill level) produces n result beats on consecutive cycles, starting in
// the cycle after the command; busy stays high until the last byte is read, as
// the byte store has a single read port. A pop or peek that moves nothing gives
// one beat. The receiver cannot stall: every done beat must be taken. The FIFO
// holds at most 1023 bytes; the store needs no clearing pass.
`default_nettype none

module byte_ring_fifo_chunked (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire brf_pkg::item_t  item,
    output logic                 done,
    output brf_pkg::result_t     result
);

    brf_pkg::state_t state_reg, state_next;

    logic [brf_pkg::PTR_W-1:0]  rptr_reg, rptr_next;
    logic [brf_pkg::PTR_W-1:0]  wptr_reg, wptr_next;
    logic [brf_pkg::PTR_W-1:0]  addr_reg, addr_next;
    logic [brf_pkg::CNT_W-1:0]  remain_reg, remain_next;
    logic [brf_pkg::CNT_W-1:0]  moved_reg, moved_next;
    logic                       done_reg, done_next;
    logic                       valid_reg, valid_next;
    logic                       last_reg, last_next;

    logic                       accept;
    logic [brf_pkg::PTR_W-1:0]  used_now;
    logic [brf_pkg::PTR_W-1:0]  wptr_inc;
    logic [brf_pkg::CNT_W-1:0]  cnt_sat;
    logic [brf_pkg::CNT_W-1:0]  n_take;
    logic                       ram_we;
    logic [brf_pkg::PTR_W-1:0]  raddr;
    logic [brf_pkg::BYTE_W-1:0] rdata;

    brf_ram #(
        .WIDTH (brf_pkg::BYTE_W),
        .DEPTH (brf_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wptr_reg),
        .wdata (item.data_in),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign busy   = (state_reg != brf_pkg::ST_IDLE);
    assign accept = start && !busy;

    // Depth is a power of two, so the pointer difference wraps to the fill level.
    assign used_now = wptr_reg - rptr_reg;
    assign wptr_inc = wptr_reg + brf_pkg::PTR_W'(1);

    always_comb
    begin
        if (item.count > brf_pkg::CNT_W'(brf_pkg::MAX_BURST))
        begin
            cnt_sat = brf_pkg::CNT_W'(brf_pkg::MAX_BURST);
        end
        else
        begin
            cnt_sat = item.count;
        end
        if (brf_pkg::PTR_W'(cnt_sat) < used_now)
        begin
            n_take = cnt_sat;
        end
        else
        begin
            n_take = brf_pkg::CNT_W'(used_now);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        rptr_next   = rptr_reg;
        wptr_next   = wptr_reg;
        addr_next   = addr_reg;
        remain_next = remain_reg;
        moved_next  = moved_reg;
        done_next   = 1'b0;
        valid_next  = 1'b0;
        last_next   = 1'b1;
        ram_we      = 1'b0;
        raddr       = rptr_reg;

        case (state_reg)
            brf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    done_next  = 1'b1;
                    moved_next = '0;
                    case (item.cmd)
                        brf_pkg::CMD_PUSH:
                        begin
                            if (wptr_inc != rptr_reg)
                            begin
                                ram_we     = 1'b1;
                                wptr_next  = wptr_inc;
                                moved_next = brf_pkg::CNT_W'(1);
                            end
                        end
                        brf_pkg::CMD_POP, brf_pkg::CMD_PEEK:
                        begin
                            // The first byte is read now; the rest stream from addr_reg.
                            moved_next = n_take;
                            if (n_take != '0)
                            begin
                                valid_next  = 1'b1;
                                last_next   = (n_take == brf_pkg::CNT_W'(1));
                                addr_next   = rptr_reg + brf_pkg::PTR_W'(1);
                                remain_next = n_take - brf_pkg::CNT_W'(1);
                                if (n_take != brf_pkg::CNT_W'(1))
                                begin
                                    state_next = brf_pkg::ST_STREAM;
                                end
                                if (item.cmd == brf_pkg::CMD_POP)
                                begin
                                    rptr_next = rptr_reg + brf_pkg::PTR_W'(n_take);
                                end
                            end
                        end
                        brf_pkg::CMD_SKIP:
                        begin
                            moved_next = n_take;
                            rptr_next  = rptr_reg + brf_pkg::PTR_W'(n_take);
                        end
                        brf_pkg::CMD_CLEAR:
                        begin
                            rptr_next = '0;
                            wptr_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            brf_pkg::ST_STREAM:
            begin
                raddr       = addr_reg;
                addr_next   = addr_reg + brf_pkg::PTR_W'(1);
                remain_next = remain_reg - brf_pkg::CNT_W'(1);
                done_next   = 1'b1;
                valid_next  = 1'b1;
                last_next   = (remain_reg == brf_pkg::CNT_W'(1));
                if (remain_reg == brf_pkg::CNT_W'(1))
                begin
                    state_next = brf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = brf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= brf_pkg::ST_IDLE;
            rptr_reg   <= '0;
            wptr_reg   <= '0;
            remain_reg <= '0;
            moved_reg  <= '0;
            done_reg   <= 1'b0;
            valid_reg  <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rptr_reg   <= rptr_next;
            wptr_reg   <= wptr_next;
            remain_reg <= remain_next;
            moved_reg  <= moved_next;
            done_reg   <= done_next;
            valid_reg  <= valid_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
    end

    // Pointers stay fixed while a burst streams out, so every beat of a
    // pop reports the level after the pop.
    assign done              = done_reg;
    assign result.data_out   = valid_reg ? rdata : '0;
    assign result.data_valid = valid_reg;
    assign result.last       = last_reg;
    assign result.moved      = moved_reg;
    assign result.used_level = used_now;
    assign result.free_level = brf_pkg::PTR_W'(brf_pkg::DEPTH - 1) - used_now;

    a_accept_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done_reg)
        else $error("accepted command produced no result beat");

    a_stream_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == brf_pkg::ST_STREAM) |-> (remain_reg != '0))
        else $error("streaming with no bytes left to read");

    a_stream_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == brf_pkg::ST_STREAM) |=> (done_reg && valid_reg))
        else $error("stream cycle did not deliver a data beat");

    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !last_reg) |=> (done_reg && valid_reg))
        else $error("burst ended without a last beat");

endmodule

`default_nettype wire
